>>> src/grsr_pkg.sv
// ----------------------------------------------------------------------------
// grsr_pkg - shared definitions for the group reversal reorderer
// Types, default sizes and the command and status groups that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package grsr_pkg;

  // Default buffer depth and stored data width.
  localparam int MAX_GROUP_DEF  = 64;
  localparam int DATA_WIDTH_DEF = 16;

  // Fixed field widths on the ports.
  localparam int VALUE_W = 16;
  localparam int GSIZE_W = 7;

  // Group size after reset.
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = 7'd1;

  // Controller states.
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } grsr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr;        // store the accepted word
    logic start;     // the accepted word closes a group: set up the drain
    logic rd_issue;  // read the next buffered word for output
  } grsr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic group_full;  // storing the word reaches the group size
    logic rd_free;     // the read stage can take a new word this cycle
    logic rd_last;     // the next read is the last one of the drain
  } grsr_sts_t;

endpackage

`default_nettype wire

>>> src/grsr_ctrl.sv
// ----------------------------------------------------------------------------
// grsr_ctrl - controller of the group reversal reorderer
// Alternates between filling the buffer and draining a finished group.
// ----------------------------------------------------------------------------
`default_nettype none

module grsr_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  input  wire logic                in_tlast,
  output logic                     in_tready,
  input  wire grsr_pkg::grsr_sts_t sts,
  output grsr_pkg::grsr_cmd_t      cmd
);

  grsr_pkg::grsr_state_t state_r;
  grsr_pkg::grsr_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grsr_pkg::ST_FILL;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.wr       = 1'b0;
    cmd.start    = 1'b0;
    cmd.rd_issue = 1'b0;
    case (state_r)
      grsr_pkg::ST_FILL: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.wr = 1'b1;
          if (sts.group_full || in_tlast) begin
            cmd.start = 1'b1;
            state_nxt = grsr_pkg::ST_DRAIN;
          end
        end
      end
      grsr_pkg::ST_DRAIN: begin
        if (sts.rd_free) begin
          cmd.rd_issue = 1'b1;
          if (sts.rd_last) begin
            state_nxt = grsr_pkg::ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = grsr_pkg::ST_FILL;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/grsr_datapath.sv
// ----------------------------------------------------------------------------
// grsr_datapath - buffer, counters and output stage of the reorderer
// Holds the group in a memory, reads it back forwards or reversed, and
// passes words through a read register and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module grsr_datapath #(
  parameter int MAX_GROUP  = grsr_pkg::MAX_GROUP_DEF,
  parameter int DATA_WIDTH = grsr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [grsr_pkg::GSIZE_W-1:0] cfg_wr_data,
  input  wire logic [grsr_pkg::VALUE_W-1:0] in_tdata,
  input  wire logic                         in_tlast,
  input  wire grsr_pkg::grsr_cmd_t          cmd,
  output grsr_pkg::grsr_sts_t               sts,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [grsr_pkg::VALUE_W-1:0]      out_tdata,
  output logic                              out_tlast,
  output logic                              out_list_last
);

  // Stored width: only the low bits that survive to the output.
  localparam int SW = (DATA_WIDTH < grsr_pkg::VALUE_W) ? DATA_WIDTH : grsr_pkg::VALUE_W;
  localparam int CW = $clog2(MAX_GROUP + 1);
  localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int KW = (CW > grsr_pkg::GSIZE_W) ? CW : grsr_pkg::GSIZE_W;

  logic [grsr_pkg::GSIZE_W-1:0] gsize_r;
  logic [CW-1:0]                fill_r;
  logic [CW-1:0]                drain_n_r;
  logic [CW-1:0]                drain_i_r;
  logic                         rev_r;
  logic                         eol_r;

  logic [SW-1:0]                mem [MAX_GROUP];

  logic                         rd_vld_r;
  logic [SW-1:0]                rd_data_r;
  logic                         rd_rl_r;
  logic                         rd_ll_r;
  logic                         out_vld_r;
  logic [SW-1:0]                out_data_r;
  logic                         out_rl_r;
  logic                         out_ll_r;

  logic [KW-1:0]                gsize_ext;
  logic [KW-1:0]                k_eff;
  logic [CW-1:0]                fill_inc;
  logic [CW-1:0]                drain_i_inc;
  logic [AW-1:0]                rd_addr;
  logic                         mv;

  // Effective group size: zero acts as one, oversize is clamped.
  always_comb begin
    gsize_ext = KW'(gsize_r);
    if (gsize_ext == '0) begin
      k_eff = KW'(1);
    end else if (gsize_ext > KW'(MAX_GROUP)) begin
      k_eff = KW'(MAX_GROUP);
    end else begin
      k_eff = gsize_ext;
    end
  end

  // Count after storing, read address and handover between stages.
  assign fill_inc    = CW'(fill_r + CW'(1));
  assign drain_i_inc = CW'(drain_i_r + CW'(1));
  assign rd_addr     = rev_r ? AW'(drain_n_r - drain_i_r - CW'(1)) : AW'(drain_i_r);
  assign mv          = rd_vld_r && (!out_vld_r || out_tready);

  assign sts.group_full = (KW'(fill_inc) >= k_eff);
  assign sts.rd_free    = !rd_vld_r || mv;
  assign sts.rd_last    = (drain_i_inc == drain_n_r);

  // Group size register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsize_r <= grsr_pkg::GSIZE_RESET;
    end else if (cfg_wr_en) begin
      gsize_r <= cfg_wr_data;
    end
  end

  // Fill and drain counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      drain_n_r <= '0;
      drain_i_r <= '0;
      rev_r     <= 1'b0;
      eol_r     <= 1'b0;
    end else begin
      if (cmd.start) begin
        fill_r    <= '0;
        drain_n_r <= fill_inc;
        drain_i_r <= '0;
        rev_r     <= sts.group_full;
        eol_r     <= in_tlast;
      end else begin
        if (cmd.wr) begin
          fill_r <= fill_inc;
        end
        if (cmd.rd_issue) begin
          drain_i_r <= drain_i_inc;
        end
      end
    end
  end

  // Group buffer with registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[fill_r[AW-1:0]] <= in_tdata[SW-1:0];
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[rd_addr];
      rd_rl_r   <= sts.rd_last;
      rd_ll_r   <= sts.rd_last && eol_r;
    end
  end

  // Valid flags of the read and output stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cmd.rd_issue) begin
        rd_vld_r <= 1'b1;
      end else if (mv) begin
        rd_vld_r <= 1'b0;
      end
      if (mv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (mv) begin
      out_data_r <= rd_data_r;
      out_rl_r   <= rd_rl_r;
      out_ll_r   <= rd_ll_r;
    end
  end

  assign out_tvalid    = out_vld_r;
  assign out_tdata     = grsr_pkg::VALUE_W'(out_data_r);
  assign out_tlast     = out_rl_r;
  assign out_list_last = out_ll_r;

  // Reads are issued only into a free read stage.
  a_issue_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> sts.rd_free)
    else $error("read issued into an occupied read stage");

  // No word is stored while a drain still has reads outstanding.
  a_no_wr_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> (drain_i_r == drain_n_r))
    else $error("word stored during a drain");

  // The fill count stays inside the buffer.
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < CW'(MAX_GROUP))
    else $error("fill count beyond buffer depth");

  // The end of the list is only marked on the last word of a run.
  a_list_last_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ll_r) |-> out_rl_r)
    else $error("list end without run end");

endmodule

`default_nettype wire

>>> src/group_reverse_stream_reorder_top.sv
// ----------------------------------------------------------------------------
// group_reverse_stream_reorder_top - group reversal reorderer
// Collects a list into groups and returns each full group reversed; a short
// group left at the end of the list comes back in arrival order.
//
// Channel  Dir  Handshake              Contents
// cfg      in   cfg_wr_en              cfg_wr_data[6:0] = group_size
// in       in   in_tvalid/in_tready    in_tdata[15:0] = elem_value,
//                                      in_tlast = end_of_list
// out      out  out_tvalid/out_tready  out_tdata[15:0] = out_value,
//                                      out_tlast = run_last,
//                                      out_tuser[0] = list_last
//
// Each word is stored and later read back through the single buffer memory
// port pair. After the word that closes the group, the first result passes
// through the read register and then the output register.
// Input is held off while a group drains; output stalls back-pressure the
// read stage and hold the drain. Reset is synchronous, active low, clears
// the counters and sets group_size to one; the buffer needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module group_reverse_stream_reorder_top #(
  parameter int MAX_GROUP  = grsr_pkg::MAX_GROUP_DEF,
  parameter int DATA_WIDTH = grsr_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_wr_en,
  input  wire logic [grsr_pkg::GSIZE_W-1:0] cfg_wr_data,  // group_size
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [grsr_pkg::VALUE_W-1:0] in_tdata,     // elem_value
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [grsr_pkg::VALUE_W-1:0]      out_tdata,    // out_value
  output logic                              out_tlast,
  output logic [0:0]                        out_tuser     // list_last
);

  grsr_pkg::grsr_cmd_t cmd;
  grsr_pkg::grsr_sts_t sts;

  // Sequencing of fill and drain.
  grsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Buffer and output stages.
  grsr_datapath #(
    .MAX_GROUP  (MAX_GROUP),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_list_last (out_tuser[0])
  );

endmodule

`default_nettype wire
